/* src/tvg_pkg.sv */
`default_nettype none

package tvg_pkg;

	// Configuration register indexes, in address order (byte address 4 * index).
	typedef enum logic [2:0] {
		REG_OUTER_RADIUS = 3'd0,
		REG_INNER_RADIUS = 3'd1,
		REG_RING_COUNT   = 3'd2,
		REG_SIDE_COUNT   = 3'd3,
		REG_RING_STEP    = 3'd4,
		REG_SIDE_STEP    = 3'd5
	} cfg_reg_t;

	// Register values after reset.
	localparam logic [15:0] OUTER_RADIUS_RST = 16'd256;
	localparam logic [15:0] INNER_RADIUS_RST = 16'd128;
	localparam logic [10:0] RING_COUNT_RST   = 11'd32;
	localparam logic [10:0] SIDE_COUNT_RST   = 11'd16;
	localparam logic [16:0] RING_STEP_RST    = 17'd2048;
	localparam logic [16:0] SIDE_STEP_RST    = 17'd4096;

	// A quarter turn in 16-bit turn fractions.
	localparam logic [15:0] QUARTER_TURN = 16'd16384;

	// Pi in Q30, used only when the sine table is built.
	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	// Fields that ride alongside the trigonometric work untouched.
	typedef struct packed {
		logic [16:0] tex_u;
		logic [15:0] tex_v;
		logic [20:0] corner_index;
		logic [20:0] next_corner_index;
		logic        quad_valid;
	} pass_t;

	// Q1.15 sine of a quarter-wave phase in 0..16384, by a fixed Taylor series.
	// Evaluated only at elaboration to fill the sine table.
	function automatic logic signed [15:0] quarter_sine(input logic [14:0] p);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		x    = (64'(p) * PI_Q30) >> 15;
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - $signed(term);
		if (sum < 64'sd0) begin
			sum = 64'sd0;
		end
		sum = (sum + 64'sd16384) >>> 15;
		if (sum > 64'sd32767) begin
			sum = 64'sd32767;
		end
		return 16'(sum);
	endfunction

	// Q1.15 sine of a full-turn phase, folded onto the first quadrant.
	function automatic logic signed [15:0] sine_entry(input logic [15:0] phase);
		logic [1:0]         quad;
		logic [14:0]        arg;
		logic signed [15:0] s;
		quad = phase[15:14];
		arg  = quad[0] ? 15'(15'd16384 - 15'(phase[13:0])) : 15'(phase[13:0]);
		s    = quarter_sine(arg);
		return quad[1] ? -s : s;
	endfunction

endpackage

`default_nettype wire

/* src/tvg_if.sv */
`default_nettype none

// Grid point channel: one (ring, side) pair per item.
interface tvg_grid_if;
	logic        valid;
	logic        ready;
	logic [10:0] ring;
	logic [9:0]  side;

	modport source (output valid, output ring, output side, input ready);
	modport sink   (input valid, input ring, input side, output ready);
endinterface

// Vertex channel: one finished vertex per item.
interface tvg_vert_if;
	logic               valid;
	logic               ready;
	logic signed [17:0] pos_x;
	logic signed [17:0] pos_y;
	logic signed [16:0] pos_z;
	logic signed [15:0] norm_x;
	logic signed [15:0] norm_y;
	logic signed [15:0] norm_z;
	logic [16:0]        tex_u;
	logic [15:0]        tex_v;
	logic [20:0]        corner_index;
	logic [20:0]        next_corner_index;
	logic               quad_valid;

	modport source (
		output valid, output pos_x, output pos_y, output pos_z,
		output norm_x, output norm_y, output norm_z, output tex_u, output tex_v,
		output corner_index, output next_corner_index, output quad_valid,
		input ready
	);
	modport sink (
		input valid, input pos_x, input pos_y, input pos_z,
		input norm_x, input norm_y, input norm_z, input tex_u, input tex_v,
		input corner_index, input next_corner_index, input quad_valid,
		output ready
	);
endinterface

`default_nettype wire

/* src/tvg_sin_rom.sv */
`default_nettype none

module tvg_sin_rom #(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic [AW-1:0]        addr_a,
	input  wire logic [AW-1:0]        addr_b,
	output logic signed [15:0]        data_a,
	output logic signed [15:0]        data_b
);
	import tvg_pkg::*;

	logic signed [15:0] rom_c [DEPTH];
	logic signed [15:0] rd_a_q;
	logic signed [15:0] rd_b_q;

	// Entry k holds the sine of phase floor(k * 65536 / DEPTH), fixed at elaboration.
	for (genvar k = 0; k < DEPTH; k++) begin : g_rom
		localparam logic [15:0] PHASE = 16'((k * 65536) / DEPTH);
		assign rom_c[k] = sine_entry(PHASE);
	end

	// Two read ports with registered data; the registers hold while stalled.
	always_ff @(posedge clk) begin
		if (en) begin
			rd_a_q <= rom_c[addr_a];
			rd_b_q <= rom_c[addr_b];
		end
	end

	assign data_a = rd_a_q;
	assign data_b = rd_b_q;

endmodule

`default_nettype wire

/* src/torus_vertex_generator.sv */
`default_nettype none

// Torus vertex generator.
// Each item on the grid channel is one (ring, side) grid point; each item on the
// vertex channel is the matching vertex: position, unit normal, texture
// coordinates, the two quad corner indices and the quad flag. Every grid item
// gives exactly one vertex item, in order.
// The APB port sets the radii, the ring and side counts and the two angle steps;
// write it only while no item is in flight.
// Pipeline: six register stages (input products, sine table read, trig products,
// radius sum, position products, output register); each stage holds one item.
// Throughput: one item per clock cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its item and each stage
// keeps its item until the stage ahead frees; the grid channel keeps accepting
// until every stage is full.
// Reset clears all stage valid bits and returns the registers to their defaults.
// TRIG_TABLE_SIZE sets the sine table depth and with it the angle resolution.
module torus_vertex_generator #(
	parameter int MAX_RINGS       = 1024,
	parameter int MAX_SIDES       = 1024,
	parameter int TRIG_TABLE_SIZE = 1024
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	tvg_grid_if.sink        grid,
	tvg_vert_if.source      vert,
	input  wire logic       psel,
	input  wire logic       penable,
	input  wire logic       pwrite,
	input  wire logic [4:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);
	import tvg_pkg::*;

	localparam int TW = $clog2(TRIG_TABLE_SIZE);

	// Configuration registers.
	logic [15:0] outer_radius_q;
	logic [15:0] inner_radius_q;
	logic [10:0] ring_count_q;
	logic [10:0] side_count_q;
	logic [16:0] ring_step_q;
	logic [16:0] side_step_q;
	logic        wr_en;

	// Stage enables and valid bits.
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// Stage 1: input products.
	logic [27:0] ufrac_s1;
	logic [15:0] vang_s1;
	logic [20:0] base_s1;
	logic [9:0]  side_s1;
	logic [10:0] next_s1;
	logic        qv_s1;
	logic [21:0] base_full;
	logic [10:0] side_inc;

	// Table addresses and side fields derived from stage 1.
	logic [15:0]   uang;
	logic [TW-1:0] u_sin_idx, u_cos_idx, v_sin_idx, v_cos_idx;
	pass_t         pass_d;

	// Stage 2: sine table outputs.
	logic signed [15:0] su_s2, cu_s2, sv_s2, cv_s2;
	pass_t              pass_s2;

	// Stage 3: trig products.
	logic signed [32:0] icv_s3, isv_s3;
	logic signed [31:0] cc_s3, cs_s3;
	logic signed [15:0] su_s3, cu_s3, sv_s3;
	pass_t              pass_s3;

	// Stage 4: radius sum and rounded products.
	logic signed [32:0] icv_rb, isv_rb;
	logic signed [31:0] cc_rb, cs_rb;
	logic signed [18:0] r_s4;
	logic signed [16:0] pz_s4;
	logic signed [16:0] nx_s4, ny_s4;
	logic signed [15:0] su_s4, cu_s4, sv_s4;
	pass_t              pass_s4;

	// Stage 5: position products and signed normals.
	logic signed [34:0] px_s5, py_s5;
	logic signed [16:0] pz_s5;
	logic signed [15:0] nx_s5, ny_s5, nz_s5;
	pass_t              pass_s5;

	// Stage 6: output register.
	logic signed [34:0] px_rb, py_rb;
	logic signed [17:0] pos_x_s6, pos_y_s6;
	logic signed [16:0] pos_z_s6;
	logic signed [15:0] norm_x_s6, norm_y_s6, norm_z_s6;
	pass_t              pass_s6;

	// Table index of a turn fraction: floor(angle * depth / 65536).
	function automatic logic [TW-1:0] idx_of(input logic [15:0] angle);
		logic [30:0] p;
		p = 31'(angle) * 31'(TRIG_TABLE_SIZE);
		return p[16 +: TW];
	endfunction

	function automatic logic signed [17:0] sat18(input logic signed [19:0] x);
		if (x > 20'sd131071) begin
			return 18'sd131071;
		end else if (x < -20'sd131072) begin
			return -18'sd131072;
		end
		return x[17:0];
	endfunction

	function automatic logic signed [16:0] sat17(input logic signed [17:0] x);
		if (x > 18'sd65535) begin
			return 17'sd65535;
		end else if (x < -18'sd65536) begin
			return -17'sd65536;
		end
		return x[16:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [17:0] x);
		if (x > 18'sd32767) begin
			return 16'sd32767;
		end else if (x < -18'sd32768) begin
			return -16'sd32768;
		end
		return x[15:0];
	endfunction

	// Configuration writes; the counts saturate to their maxima.
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_radius_q <= OUTER_RADIUS_RST;
			inner_radius_q <= INNER_RADIUS_RST;
			ring_count_q   <= RING_COUNT_RST;
			side_count_q   <= SIDE_COUNT_RST;
			ring_step_q    <= RING_STEP_RST;
			side_step_q    <= SIDE_STEP_RST;
		end else if (wr_en) begin
			case (cfg_reg_t'(paddr[4:2]))
				REG_OUTER_RADIUS: outer_radius_q <= pwdata[15:0];
				REG_INNER_RADIUS: inner_radius_q <= pwdata[15:0];
				REG_RING_COUNT: begin
					if (32'(pwdata[10:0]) > 32'(MAX_RINGS)) begin
						ring_count_q <= 11'(MAX_RINGS);
					end else begin
						ring_count_q <= pwdata[10:0];
					end
				end
				REG_SIDE_COUNT: begin
					if (32'(pwdata[10:0]) > 32'(MAX_SIDES)) begin
						side_count_q <= 11'(MAX_SIDES);
					end else begin
						side_count_q <= pwdata[10:0];
					end
				end
				REG_RING_STEP: ring_step_q <= pwdata[16:0];
				REG_SIDE_STEP: side_step_q <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (cfg_reg_t'(paddr[4:2]))
			REG_OUTER_RADIUS: prdata = 32'(outer_radius_q);
			REG_INNER_RADIUS: prdata = 32'(inner_radius_q);
			REG_RING_COUNT:   prdata = 32'(ring_count_q);
			REG_SIDE_COUNT:   prdata = 32'(side_count_q);
			REG_RING_STEP:    prdata = 32'(ring_step_q);
			REG_SIDE_STEP:    prdata = 32'(side_step_q);
			default:          prdata = '0;
		endcase
	end

	// A stage takes a new item when it is empty or its item moves on.
	assign adv_s6     = !v_s6 || vert.ready;
	assign adv_s5     = !v_s5 || adv_s6;
	assign adv_s4     = !v_s4 || adv_s5;
	assign adv_s3     = !v_s3 || adv_s4;
	assign adv_s2     = !v_s2 || adv_s3;
	assign adv_s1     = !v_s1 || adv_s2;
	assign grid.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= grid.valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
			if (adv_s5) v_s5 <= v_s4;
			if (adv_s6) v_s6 <= v_s5;
		end
	end

	// Stage 1: ring and side turn fractions, row base index and next side.
	assign base_full = 22'(grid.ring) * 22'(side_count_q);
	assign side_inc  = 11'(grid.side) + 11'd1;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			ufrac_s1 <= 28'(grid.ring) * 28'(ring_step_q);
			vang_s1  <= 16'(grid.side) * side_step_q[15:0];
			base_s1  <= base_full[20:0];
			side_s1  <= grid.side;
			next_s1  <= (side_inc >= side_count_q) ? 11'd0 : side_inc;
			qv_s1    <= (grid.ring < ring_count_q);
		end
	end

	// Table addresses for sine and cosine of both angles; side fields finish here.
	assign uang      = ufrac_s1[15:0];
	assign u_sin_idx = idx_of(uang);
	assign u_cos_idx = idx_of(uang + QUARTER_TURN);
	assign v_sin_idx = idx_of(vang_s1);
	assign v_cos_idx = idx_of(vang_s1 + QUARTER_TURN);

	always_comb begin
		pass_d.tex_u             = (ufrac_s1 > 28'd65536) ? 17'd65536 : ufrac_s1[16:0];
		pass_d.tex_v             = vang_s1;
		pass_d.corner_index      = base_s1 + 21'(side_s1);
		pass_d.next_corner_index = base_s1 + 21'(next_s1);
		pass_d.quad_valid        = qv_s1;
	end

	// Stage 2: sine table reads, one table per angle.
	tvg_sin_rom #(
		.DEPTH (TRIG_TABLE_SIZE)
	) u_rom_u (
		.clk    (clk),
		.en     (adv_s2),
		.addr_a (u_sin_idx),
		.addr_b (u_cos_idx),
		.data_a (su_s2),
		.data_b (cu_s2)
	);

	tvg_sin_rom #(
		.DEPTH (TRIG_TABLE_SIZE)
	) u_rom_v (
		.clk    (clk),
		.en     (adv_s2),
		.addr_a (v_sin_idx),
		.addr_b (v_cos_idx),
		.data_a (sv_s2),
		.data_b (cv_s2)
	);

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			pass_s2 <= pass_d;
		end
	end

	// Stage 3: tube radius and normal products.
	always_ff @(posedge clk) begin
		if (adv_s3) begin
			icv_s3  <= $signed({1'b0, inner_radius_q}) * cv_s2;
			isv_s3  <= $signed({1'b0, inner_radius_q}) * sv_s2;
			cc_s3   <= cv_s2 * cu_s2;
			cs_s3   <= cv_s2 * su_s2;
			su_s3   <= su_s2;
			cu_s3   <= cu_s2;
			sv_s3   <= sv_s2;
			pass_s3 <= pass_s2;
		end
	end

	// Stage 4: round the products half up and form the ring radius r.
	assign icv_rb = icv_s3 + 33'sd16384;
	assign isv_rb = isv_s3 + 33'sd16384;
	assign cc_rb  = cc_s3 + 32'sd16384;
	assign cs_rb  = cs_s3 + 32'sd16384;

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			r_s4    <= $signed({3'b000, outer_radius_q}) + 19'($signed(icv_rb[32:15]));
			pz_s4   <= sat17(isv_rb[32:15]);
			nx_s4   <= cc_rb[31:15];
			ny_s4   <= cs_rb[31:15];
			su_s4   <= su_s3;
			cu_s4   <= cu_s3;
			sv_s4   <= sv_s3;
			pass_s4 <= pass_s3;
		end
	end

	// Stage 5: position products; the normal flips with the sign of r and
	// vanishes where r is zero.
	always_ff @(posedge clk) begin
		if (adv_s5) begin
			px_s5   <= r_s4 * cu_s4;
			py_s5   <= r_s4 * su_s4;
			pz_s5   <= pz_s4;
			pass_s5 <= pass_s4;
			if (r_s4 == 19'sd0) begin
				nx_s5 <= '0;
				ny_s5 <= '0;
				nz_s5 <= '0;
			end else if (r_s4 < 19'sd0) begin
				nx_s5 <= sat16(-18'(nx_s4));
				ny_s5 <= sat16(-18'(ny_s4));
				nz_s5 <= sat16(-18'(sv_s4));
			end else begin
				nx_s5 <= sat16(18'(nx_s4));
				ny_s5 <= sat16(18'(ny_s4));
				nz_s5 <= sv_s4;
			end
		end
	end

	// Stage 6: round and saturate the position; this is the output register.
	assign px_rb = px_s5 + 35'sd16384;
	assign py_rb = py_s5 + 35'sd16384;

	always_ff @(posedge clk) begin
		if (adv_s6) begin
			pos_x_s6  <= sat18(px_rb[34:15]);
			pos_y_s6  <= sat18(py_rb[34:15]);
			pos_z_s6  <= pz_s5;
			norm_x_s6 <= nx_s5;
			norm_y_s6 <= ny_s5;
			norm_z_s6 <= nz_s5;
			pass_s6   <= pass_s5;
		end
	end

	assign vert.valid             = v_s6;
	assign vert.pos_x             = pos_x_s6;
	assign vert.pos_y             = pos_y_s6;
	assign vert.pos_z             = pos_z_s6;
	assign vert.norm_x            = norm_x_s6;
	assign vert.norm_y            = norm_y_s6;
	assign vert.norm_z            = norm_z_s6;
	assign vert.tex_u             = pass_s6.tex_u;
	assign vert.tex_v             = pass_s6.tex_v;
	assign vert.corner_index      = pass_s6.corner_index;
	assign vert.next_corner_index = pass_s6.next_corner_index;
	assign vert.quad_valid        = pass_s6.quad_valid;

`ifndef SYNTHESIS
	// The grid channel is only blocked when every stage is full and the output stalls.
	a_ready_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		!grid.ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && !vert.ready))
		else $error("grid channel blocked while the pipeline has room");

	// A stalled stage four keeps its item.
	a_s4_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !adv_s5) |=> (v_s4 && $stable(r_s4) && $stable(sv_s4)))
		else $error("stage four item changed while stalled");

	// A zero ring radius gives a zero normal.
	a_zero_normal: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && adv_s5 && (r_s4 == 19'sd0)) |=>
			(nx_s5 == 16'sd0 && ny_s5 == 16'sd0 && nz_s5 == 16'sd0))
		else $error("normal not cleared for zero radius");

	// With a positive radius the normal's z component is the side sine itself.
	a_normal_z: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && adv_s5 && (r_s4 > 19'sd0)) |=> (nz_s5 == $past(sv_s4)))
		else $error("normal z differs from side sine");

	// The ring texture coordinate never passes one whole turn.
	a_tex_u_cap: assert property (@(posedge clk) disable iff (!arst_n)
		vert.valid |-> (vert.tex_u <= 17'd65536))
		else $error("tex_u above one turn");
`endif

endmodule

`default_nettype wire
